@@ hw/rtl/source_text_tokenizer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit_macros.svh
// Assertion macros shared by the tokenizer checkers
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define STT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define STT_ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants of the source text tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int FIFO_DEPTH      = 4;

  // token kinds
  localparam logic [3:0] KIND_ILLEGAL = 4'd0;
  localparam logic [3:0] KIND_EOF     = 4'd1;
  localparam logic [3:0] KIND_WORD    = 4'd2;
  localparam logic [3:0] KIND_INT     = 4'd3;
  localparam logic [3:0] KIND_FLOAT   = 4'd4;
  localparam logic [3:0] KIND_DOT     = 4'd5;
  localparam logic [3:0] KIND_ARROW   = 4'd6;
  localparam logic [3:0] KIND_LPAREN  = 4'd7;
  localparam logic [3:0] KIND_RPAREN  = 4'd8;
  localparam logic [3:0] KIND_LBRACE  = 4'd9;
  localparam logic [3:0] KIND_RBRACE  = 4'd10;
  localparam logic [3:0] KIND_COLON   = 4'd11;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_DOT     = 3'd3,
    MODE_MINUS   = 3'd4,
    MODE_SLASH   = 3'd5,
    MODE_COMMENT = 3'd6
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } stt_in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } stt_out_t;

  // one result produced by a step
  typedef struct packed {
    logic     vld;
    stt_out_t beat;
  } stt_slot_t;

endpackage

@@ hw/rtl/stt_step.sv @@
// ----------------------------------------------------------------------------
// stt_step
// Lexer state and per-byte decode: up to two token beats per byte
// ----------------------------------------------------------------------------
module stt_step #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  stt_pkg::stt_in_t   in_data,
  output stt_pkg::stt_slot_t slot0,
  output stt_pkg::stt_slot_t slot1
);

  localparam int EXT_W = (OFFSET_BITS + 1 > 17) ? OFFSET_BITS + 1 : 17;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  stt_pkg::lex_mode_t     mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic                   has_dot_r, has_dot_nxt;
  logic                   prev_dot_r, prev_dot_nxt;

  logic [7:0]       c;
  logic             is_letter, is_digit, is_blank;
  logic [EXT_W-1:0] pos_ext, start_ext, pend_len;
  logic             pend_emits;
  logic [3:0]       pend_kind;
  logic             do_flush, fresh, adv, clr;
  logic             fl_vld, mn_vld;
  logic [3:0]       mn_kind;
  logic [EXT_W-1:0] mn_start, mn_len;
  stt_pkg::stt_out_t fl_beat, mn_beat;

  // clamp an offset or length to the 16-bit field
  function automatic logic [15:0] sat16(input logic [EXT_W-1:0] v);
    logic [15:0] r;
    r = (|v[EXT_W-1:16]) ? 16'hFFFF : v[15:0];
    return r;
  endfunction

  // character classes
  assign c         = in_data.char_in;
  assign is_letter = (c >= stt_pkg::CH_LC_A && c <= stt_pkg::CH_LC_Z) ||
                     (c >= stt_pkg::CH_UC_A && c <= stt_pkg::CH_UC_Z) ||
                     (c == stt_pkg::CH_UNDER);
  assign is_digit  = (c >= stt_pkg::CH_ZERO && c <= stt_pkg::CH_NINE);
  assign is_blank  = (c == stt_pkg::CH_SPACE) || (c == stt_pkg::CH_TAB) ||
                     (c == stt_pkg::CH_LF) || (c == stt_pkg::CH_CR);

  assign pos_ext   = EXT_W'(pos_r);
  assign start_ext = EXT_W'(start_r);
  assign pend_len  = pos_ext - start_ext;

  // kind of the pending token if it ends here
  always_comb begin
    pend_emits = 1'b1;
    pend_kind  = stt_pkg::KIND_ILLEGAL;
    case (mode_r)
      stt_pkg::MODE_WORD:   pend_kind = stt_pkg::KIND_WORD;
      stt_pkg::MODE_NUMBER: pend_kind = has_dot_r ? stt_pkg::KIND_FLOAT : stt_pkg::KIND_INT;
      stt_pkg::MODE_DOT:    pend_kind = stt_pkg::KIND_DOT;
      stt_pkg::MODE_MINUS:  pend_kind = stt_pkg::KIND_ILLEGAL;
      stt_pkg::MODE_SLASH:  pend_kind = stt_pkg::KIND_ILLEGAL;
      default:              pend_emits = 1'b0;
    endcase
  end

  // next state and the main token of this byte
  always_comb begin
    mode_nxt     = mode_r;
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    has_dot_nxt  = has_dot_r;
    prev_dot_nxt = prev_dot_r;
    do_flush     = 1'b0;
    fresh        = 1'b0;
    adv          = 1'b0;
    clr          = 1'b0;
    mn_vld       = 1'b0;
    mn_kind      = stt_pkg::KIND_ILLEGAL;
    mn_start     = pos_ext;
    mn_len       = '0;

    if (in_data.end_of_text) begin
      do_flush = 1'b1;
      mn_vld   = 1'b1;
      mn_kind  = stt_pkg::KIND_EOF;
      clr      = 1'b1;
    end else begin
      case (mode_r)
        stt_pkg::MODE_WORD: begin
          if (is_letter) begin
            adv = 1'b1;
          end else begin
            do_flush = 1'b1;
            fresh    = 1'b1;
          end
        end
        stt_pkg::MODE_NUMBER: begin
          if (is_digit) begin
            prev_dot_nxt = 1'b0;
            adv          = 1'b1;
          end else if (c == stt_pkg::CH_DOT) begin
            if (prev_dot_r) begin
              // second dot in a row closes the number and opens a dot
              do_flush  = 1'b1;
              mode_nxt  = stt_pkg::MODE_DOT;
              start_nxt = pos_r;
            end else begin
              has_dot_nxt  = 1'b1;
              prev_dot_nxt = 1'b1;
            end
            adv = 1'b1;
          end else begin
            do_flush = 1'b1;
            fresh    = 1'b1;
          end
        end
        stt_pkg::MODE_DOT: begin
          if (is_digit) begin
            mode_nxt     = stt_pkg::MODE_NUMBER;
            has_dot_nxt  = 1'b1;
            prev_dot_nxt = 1'b0;
            adv          = 1'b1;
          end else begin
            do_flush = 1'b1;
            fresh    = 1'b1;
          end
        end
        stt_pkg::MODE_MINUS: begin
          if (c == stt_pkg::CH_GT) begin
            mn_vld   = 1'b1;
            mn_kind  = stt_pkg::KIND_ARROW;
            mn_start = start_ext;
            mn_len   = pend_len + EXT_W'(1);
            mode_nxt = stt_pkg::MODE_IDLE;
            adv      = 1'b1;
          end else begin
            do_flush = 1'b1;
            fresh    = 1'b1;
          end
        end
        stt_pkg::MODE_SLASH: begin
          if (c == stt_pkg::CH_SLASH) begin
            mode_nxt = stt_pkg::MODE_COMMENT;
            adv      = 1'b1;
          end else begin
            do_flush = 1'b1;
            fresh    = 1'b1;
          end
        end
        stt_pkg::MODE_COMMENT: begin
          if (c == stt_pkg::CH_NUL) begin
            mn_vld  = 1'b1;
            mn_kind = stt_pkg::KIND_EOF;
            clr     = 1'b1;
          end else begin
            if (c == stt_pkg::CH_LF) begin
              mode_nxt = stt_pkg::MODE_IDLE;
            end
            adv = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase

      // byte starts from idle
      if (fresh) begin
        mode_nxt = stt_pkg::MODE_IDLE;
        adv      = 1'b1;
        if (c == stt_pkg::CH_NUL) begin
          mn_vld  = 1'b1;
          mn_kind = stt_pkg::KIND_EOF;
          clr     = 1'b1;
        end else if (is_blank) begin
          adv = 1'b1;
        end else if (is_letter) begin
          mode_nxt  = stt_pkg::MODE_WORD;
          start_nxt = pos_r;
        end else if (is_digit) begin
          mode_nxt     = stt_pkg::MODE_NUMBER;
          start_nxt    = pos_r;
          has_dot_nxt  = 1'b0;
          prev_dot_nxt = 1'b0;
        end else if (c == stt_pkg::CH_DOT) begin
          mode_nxt  = stt_pkg::MODE_DOT;
          start_nxt = pos_r;
        end else if (c == stt_pkg::CH_MINUS) begin
          mode_nxt  = stt_pkg::MODE_MINUS;
          start_nxt = pos_r;
        end else if (c == stt_pkg::CH_SLASH) begin
          mode_nxt  = stt_pkg::MODE_SLASH;
          start_nxt = pos_r;
        end else begin
          mn_vld = 1'b1;
          mn_len = EXT_W'(1);
          if (c == stt_pkg::CH_LPAREN) begin
            mn_kind = stt_pkg::KIND_LPAREN;
          end else if (c == stt_pkg::CH_RPAREN) begin
            mn_kind = stt_pkg::KIND_RPAREN;
          end else if (c == stt_pkg::CH_LBRACE) begin
            mn_kind = stt_pkg::KIND_LBRACE;
          end else if (c == stt_pkg::CH_RBRACE) begin
            mn_kind = stt_pkg::KIND_RBRACE;
          end else if (c == stt_pkg::CH_COLON) begin
            mn_kind = stt_pkg::KIND_COLON;
          end else begin
            mn_kind = stt_pkg::KIND_ILLEGAL;
          end
        end
      end
    end

    // saturating byte offset
    if (adv && pos_r != POS_MAX) begin
      pos_nxt = pos_r + OFFSET_BITS'(1);
    end

    // end of text returns everything to reset
    if (clr) begin
      mode_nxt     = stt_pkg::MODE_IDLE;
      pos_nxt      = '0;
      start_nxt    = '0;
      has_dot_nxt  = 1'b0;
      prev_dot_nxt = 1'b0;
    end
  end

  // pack flushed and main tokens into two ordered slots
  assign fl_vld = do_flush && pend_emits;

  always_comb begin
    fl_beat.token_kind   = pend_kind;
    fl_beat.token_start  = sat16(start_ext);
    fl_beat.token_length = sat16(pend_len);
    fl_beat.last_of_run  = !mn_vld;
    mn_beat.token_kind   = mn_kind;
    mn_beat.token_start  = sat16(mn_start);
    mn_beat.token_length = sat16(mn_len);
    mn_beat.last_of_run  = 1'b1;
    slot0.vld  = fl_vld || mn_vld;
    slot0.beat = fl_vld ? fl_beat : mn_beat;
    slot1.vld  = fl_vld && mn_vld;
    slot1.beat = mn_beat;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= stt_pkg::MODE_IDLE;
      pos_r      <= '0;
      start_r    <= '0;
      has_dot_r  <= 1'b0;
      prev_dot_r <= 1'b0;
    end else if (step_en) begin
      mode_r     <= mode_nxt;
      pos_r      <= pos_nxt;
      start_r    <= start_nxt;
      has_dot_r  <= has_dot_nxt;
      prev_dot_r <= prev_dot_nxt;
    end
  end

endmodule

@@ hw/rtl/source_text_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming tokenizer: one source byte in, up to two token descriptors out
// ----------------------------------------------------------------------------
//   channel  direction  payload     handshake
//   in_      input      stt_in_t    in_valid / in_ready
//   out_     output     stt_out_t   out_valid / out_ready
//
// One byte per cycle while the queue has room; a byte waits in the input
// register, is decoded combinationally in stt_step and goes to the four-entry
// queue that drives out_. Bytes that end two tokens need two output beats, so
// a run of them limits the rate to one beat per cycle while out_ready is high.
// Synchronous active-low reset clears the lexer state and empties the queue.
// A stalled output stops input only once the queue has no room for two beats.
module source_text_tokenizer_unit #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stt_pkg::stt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output stt_pkg::stt_out_t out_data
);

  localparam int DEPTH = stt_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic               in_vld_r;
  stt_pkg::stt_in_t   in_data_r;
  logic               proc, pop;
  stt_pkg::stt_slot_t slot0, slot1;

  stt_pkg::stt_out_t  queue_r [DEPTH];
  logic [PTR_W-1:0]   head_r, tail_r, tail_p1;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, n_push;

  // process when the queue has room for two beats
  assign proc     = in_vld_r && (cnt_r <= CNT_W'(DEPTH - 2));
  assign in_ready = !in_vld_r || proc;
  assign pop      = out_valid && out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  stt_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (proc),
    .in_data (in_data_r),
    .slot0   (slot0),
    .slot1   (slot1)
  );

  // result queue
  assign tail_p1 = tail_r + PTR_W'(1);
  assign n_push  = proc ? (CNT_W'(slot0.vld) + CNT_W'(slot1.vld)) : '0;
  assign cnt_nxt = cnt_r + n_push - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (proc && slot0.vld) begin
      queue_r[tail_r] <= slot0.beat;
    end
    if (proc && slot1.vld) begin
      queue_r[tail_p1] <= slot1.beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      tail_r <= tail_r + PTR_W'(n_push);
      if (pop) begin
        head_r <= head_r + PTR_W'(1);
      end
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = queue_r[head_r];

endmodule

@@ hw/rtl/stt_checker.sv @@
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the tokenizer, bound to the top level
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_unit_macros.svh"

module stt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input stt_pkg::stt_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input stt_pkg::stt_out_t out_data
);

  logic single_kind;
  logic eof_beat, eof_ok;
  logic punct_beat, punct_ok;
  logic in_stall, out_stall;

  // punctuation kinds are always one byte long
  assign single_kind = (out_data.token_kind == stt_pkg::KIND_LPAREN) ||
                       (out_data.token_kind == stt_pkg::KIND_RPAREN) ||
                       (out_data.token_kind == stt_pkg::KIND_LBRACE) ||
                       (out_data.token_kind == stt_pkg::KIND_RBRACE) ||
                       (out_data.token_kind == stt_pkg::KIND_COLON);

  // beat shapes and stall conditions
  assign eof_beat   = out_valid && (out_data.token_kind == stt_pkg::KIND_EOF);
  assign eof_ok     = (out_data.token_length == 16'd0) && out_data.last_of_run;
  assign punct_beat = out_valid && single_kind;
  assign punct_ok   = (out_data.token_length == 16'd1) && out_data.last_of_run;
  assign in_stall   = in_valid && !in_ready;
  assign out_stall  = out_valid && !out_ready;

  // stalled beat holds
  `STT_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "out beat changed")
  // offered input beat holds until taken
  `STT_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(in_data), "in beat changed")
  // queue empties on reset
  `STT_ASSERT_NEXT_ANY(a_reset_empty, !rst_n, !out_valid, "out_valid after reset")
  // eof carries no length and closes its run
  `STT_ASSERT_SAME(a_eof_shape, eof_beat, eof_ok, "bad eof beat")
  // punctuation length
  `STT_ASSERT_SAME(a_punct_len, punct_beat, punct_ok, "bad punctuation beat")

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/sv/source_text_tokenizer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit_tb
// Self-checking bench for the streaming tokenizer: source bytes go in over a
// valid/ready channel, and every token beat that comes out is checked against
// a cycle-free predictor that tracks the lexer mode, offsets and dot flags.
// Short directed texts come first, then a long output hold-off, and random
// token-shaped text under several idle patterns.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit_tb;

  localparam int POS_MAX        = (1 << stt_pkg::OFFSET_BITS_DEF) - 1;
  localparam int FIELD_MAX      = 16'hFFFF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASE_ITEMS    = 335;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  stt_pkg::stt_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  stt_pkg::stt_out_t out_data;

  source_text_tokenizer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // run bookkeeping
  int idle_cycles    = 0;
  int error_count    = 0;
  int bytes_sent     = 0;
  int tokens_checked = 0;
  int texts_seen     = 0;

  // traffic shaping
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_request  = 0;
  int hold_left     = 0;

  // predictor state
  stt_pkg::lex_mode_t scan_mode    = stt_pkg::MODE_IDLE;
  int                 scan_pos     = 0;
  int                 token_origin = 0;
  logic               seen_dot     = 1'b0;
  logic               last_was_dot = 1'b0;
  stt_pkg::stt_out_t  step_tokens[$];
  stt_pkg::stt_out_t  expected_tokens[$];

  // character classes
  function automatic logic is_letter(logic [7:0] c);
    return (c >= stt_pkg::CH_LC_A && c <= stt_pkg::CH_LC_Z) ||
           (c >= stt_pkg::CH_UC_A && c <= stt_pkg::CH_UC_Z) || c == stt_pkg::CH_UNDER;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= stt_pkg::CH_ZERO && c <= stt_pkg::CH_NINE;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB ||
           c == stt_pkg::CH_LF || c == stt_pkg::CH_CR;
  endfunction

  function automatic int clip16(int v);
    return (v > FIELD_MAX) ? FIELD_MAX : v;
  endfunction

  function void add_token(logic [3:0] kind, int start, int len);
    stt_pkg::stt_out_t t;
    t.token_kind   = kind;
    t.token_start  = 16'(clip16(start));
    t.token_length = 16'(clip16(len));
    t.last_of_run  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function void restart_scan();
    scan_mode    = stt_pkg::MODE_IDLE;
    scan_pos     = 0;
    token_origin = 0;
    seen_dot     = 1'b0;
    last_was_dot = 1'b0;
  endfunction

  function void step_pos();
    if (scan_pos < POS_MAX) scan_pos++;
  endfunction

  // emit whatever token is open, ending just before offset p
  function void close_pending(int p);
    case (scan_mode)
      stt_pkg::MODE_WORD:
        add_token(stt_pkg::KIND_WORD, token_origin, p - token_origin);
      stt_pkg::MODE_NUMBER:
        add_token(seen_dot ? stt_pkg::KIND_FLOAT : stt_pkg::KIND_INT, token_origin,
                  p - token_origin);
      stt_pkg::MODE_DOT:
        add_token(stt_pkg::KIND_DOT, token_origin, p - token_origin);
      stt_pkg::MODE_MINUS,
      stt_pkg::MODE_SLASH:
        add_token(stt_pkg::KIND_ILLEGAL, token_origin, p - token_origin);
      default: ;
    endcase
    scan_mode = stt_pkg::MODE_IDLE;
  endfunction

  // one source byte through the lexer
  function void scan_byte(logic [7:0] c, logic eot);
    int p;
    p = scan_pos;
    if (eot) begin
      close_pending(p);
      add_token(stt_pkg::KIND_EOF, p, 0);
      restart_scan();
      return;
    end
    case (scan_mode)
      stt_pkg::MODE_WORD: begin
        if (is_letter(c)) begin
          step_pos();
          return;
        end
        close_pending(p);
      end
      stt_pkg::MODE_NUMBER: begin
        if (is_digit(c)) begin
          last_was_dot = 1'b0;
          step_pos();
          return;
        end
        if (c == stt_pkg::CH_DOT) begin
          // two dots in a row: number ends after the first one
          if (last_was_dot) begin
            close_pending(p);
            scan_mode    = stt_pkg::MODE_DOT;
            token_origin = p;
          end else begin
            seen_dot     = 1'b1;
            last_was_dot = 1'b1;
          end
          step_pos();
          return;
        end
        close_pending(p);
      end
      stt_pkg::MODE_DOT: begin
        if (is_digit(c)) begin
          scan_mode    = stt_pkg::MODE_NUMBER;
          seen_dot     = 1'b1;
          last_was_dot = 1'b0;
          step_pos();
          return;
        end
        close_pending(p);
      end
      stt_pkg::MODE_MINUS: begin
        if (c == stt_pkg::CH_GT) begin
          add_token(stt_pkg::KIND_ARROW, token_origin, p - token_origin + 1);
          scan_mode = stt_pkg::MODE_IDLE;
          step_pos();
          return;
        end
        close_pending(p);
      end
      stt_pkg::MODE_SLASH: begin
        if (c == stt_pkg::CH_SLASH) begin
          scan_mode = stt_pkg::MODE_COMMENT;
          step_pos();
          return;
        end
        close_pending(p);
      end
      stt_pkg::MODE_COMMENT: begin
        if (c == stt_pkg::CH_NUL) begin
          add_token(stt_pkg::KIND_EOF, p, 0);
          restart_scan();
          return;
        end
        if (c == stt_pkg::CH_LF) scan_mode = stt_pkg::MODE_IDLE;
        step_pos();
        return;
      end
      default: scan_mode = stt_pkg::MODE_IDLE;
    endcase

    // byte starts fresh
    if (c == stt_pkg::CH_NUL) begin
      add_token(stt_pkg::KIND_EOF, p, 0);
      restart_scan();
      return;
    end
    if (is_blank(c)) begin
      // blanks only advance the offset
    end else if (is_letter(c)) begin
      scan_mode    = stt_pkg::MODE_WORD;
      token_origin = p;
    end else if (is_digit(c)) begin
      scan_mode    = stt_pkg::MODE_NUMBER;
      token_origin = p;
      seen_dot     = 1'b0;
      last_was_dot = 1'b0;
    end else if (c == stt_pkg::CH_DOT) begin
      scan_mode    = stt_pkg::MODE_DOT;
      token_origin = p;
    end else if (c == stt_pkg::CH_MINUS) begin
      scan_mode    = stt_pkg::MODE_MINUS;
      token_origin = p;
    end else if (c == stt_pkg::CH_SLASH) begin
      scan_mode    = stt_pkg::MODE_SLASH;
      token_origin = p;
    end else if (c == stt_pkg::CH_LPAREN) begin
      add_token(stt_pkg::KIND_LPAREN, p, 1);
    end else if (c == stt_pkg::CH_RPAREN) begin
      add_token(stt_pkg::KIND_RPAREN, p, 1);
    end else if (c == stt_pkg::CH_LBRACE) begin
      add_token(stt_pkg::KIND_LBRACE, p, 1);
    end else if (c == stt_pkg::CH_RBRACE) begin
      add_token(stt_pkg::KIND_RBRACE, p, 1);
    end else if (c == stt_pkg::CH_COLON) begin
      add_token(stt_pkg::KIND_COLON, p, 1);
    end else begin
      add_token(stt_pkg::KIND_ILLEGAL, p, 1);
    end
    step_pos();
  endfunction

  // tokens expected from one accepted input beat
  function void predict_tokens(stt_pkg::stt_in_t beat);
    step_tokens.delete();
    scan_byte(beat.char_in, beat.end_of_text);
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    foreach (step_tokens[i]) begin
      if (step_tokens[i].token_kind == stt_pkg::KIND_EOF) texts_seen++;
      expected_tokens.push_back(step_tokens[i]);
    end
  endfunction

  task report_mismatch(string what, int got_v, int want_v);
    error_count++;
    $display("mismatch at token beat %0d: %s got %0d expected %0d",
             tokens_checked, what, got_v, want_v);
  endtask

  task check_token(stt_pkg::stt_out_t got);
    stt_pkg::stt_out_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("unexpected token beat, kind", got.token_kind, -1);
      return;
    end
    want = expected_tokens.pop_front();
    if (got.token_kind !== want.token_kind)
      report_mismatch("token_kind", got.token_kind, want.token_kind);
    if (got.token_start !== want.token_start)
      report_mismatch("token_start", got.token_start, want.token_start);
    if (got.token_length !== want.token_length)
      report_mismatch("token_length", got.token_length, want.token_length);
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
    tokens_checked++;
  endtask

  // monitor: predict on input beats, check output beats, track progress
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_tokens(in_data);
    if (rst_n && out_valid && out_ready) check_token(out_data);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("source_text_tokenizer_unit_tb: FAIL");
    $finish;
  end

  // offer one byte, with random idle cycles first, and wait for acceptance
  task send_byte(logic [7:0] c, logic eot);
    stt_pkg::stt_in_t beat;
    beat.char_in     = c;
    beat.end_of_text = eot;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(stt_pkg::CH_LC_A + r);
    if (r < 52) return 8'(stt_pkg::CH_UC_A + r - 26);
    return stt_pkg::CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(stt_pkg::CH_ZERO + $urandom_range(0, 9));
  endfunction

  // one random token-shaped piece of text
  task send_fragment();
    logic [7:0] punct[5];
    logic [7:0] blanks[4];
    logic [7:0] b;
    int         kind;
    int         n;
    punct  = '{stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN, stt_pkg::CH_LBRACE,
               stt_pkg::CH_RBRACE, stt_pkg::CH_COLON};
    blanks = '{stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_LF, stt_pkg::CH_CR};
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(rand_letter(), 1'b0);
    end else if (kind < 35) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(rand_digit(), 1'b0);
      n = $urandom_range(0, 3);
      if (n == 1) begin
        send_byte(stt_pkg::CH_DOT, 1'b0);
        n = $urandom_range(0, 3);
        repeat (n) send_byte(rand_digit(), 1'b0);
      end else if (n == 2) begin
        send_byte(stt_pkg::CH_DOT, 1'b0);
        send_byte(stt_pkg::CH_DOT, 1'b0);
      end else if (n == 3) begin
        send_byte(stt_pkg::CH_DOT, 1'b0);
        send_byte(rand_digit(), 1'b0);
        send_byte(stt_pkg::CH_DOT, 1'b0);
        send_byte(rand_digit(), 1'b0);
      end
    end else if (kind < 40) begin
      send_byte(stt_pkg::CH_DOT, 1'b0);
      if ($urandom_range(0, 1) == 1) send_byte(rand_digit(), 1'b0);
    end else if (kind < 45) begin
      send_byte(stt_pkg::CH_MINUS, 1'b0);
      if ($urandom_range(0, 2) != 0) send_byte(stt_pkg::CH_GT, 1'b0);
    end else if (kind < 50) begin
      send_byte(stt_pkg::CH_SLASH, 1'b0);
      if ($urandom_range(0, 3) != 0) begin
        send_byte(stt_pkg::CH_SLASH, 1'b0);
        n = $urandom_range(0, 8);
        repeat (n) begin
          b = 8'($urandom_range(1, 255));
          send_byte((b == stt_pkg::CH_LF) ? stt_pkg::CH_SPACE : b, 1'b0);
        end
        // comment closed by newline, now and then by end of text
        send_byte(($urandom_range(0, 7) == 0) ? stt_pkg::CH_NUL : stt_pkg::CH_LF, 1'b0);
      end
    end else if (kind < 60) begin
      send_byte(punct[$urandom_range(0, 4)], 1'b0);
    end else if (kind < 80) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(blanks[$urandom_range(0, 3)], 1'b0);
    end else if (kind < 90) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 95) begin
      send_byte(stt_pkg::CH_NUL, 1'b0);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // words, integers, floats, a dot pair and lone dots
  task test_words_and_numbers();
    send_text("aZ_ 09 1..2 .7 .");
    send_byte(stt_pkg::CH_TAB, 1'b0);
    wait_drained();
  endtask

  // arrow, lone minus and slash, punctuation, high bytes
  task test_operators();
    send_text("->-x/(){}:");
    send_byte(stt_pkg::CH_CR, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(stt_pkg::CH_LF, 1'b0);
    wait_drained();
  endtask

  // comment to newline, then a comment cut by a zero byte
  task test_comments();
    send_text("//c");
    send_byte(stt_pkg::CH_LF, 1'b0);
    send_text("//");
    send_byte(stt_pkg::CH_NUL, 1'b0);
    wait_drained();
  endtask

  // end marker with a pending minus, slash, dot or number, and on an idle lexer
  task test_end_of_text();
    send_byte(stt_pkg::CH_MINUS, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(stt_pkg::CH_SLASH, 1'b0);
    send_byte(stt_pkg::CH_NUL, 1'b1);
    send_byte(stt_pkg::CH_DOT, 1'b0);
    send_byte(stt_pkg::CH_UC_A, 1'b1);
    send_text("3.");
    send_byte(stt_pkg::CH_SPACE, 1'b1);
    send_text("ab");
    send_byte(stt_pkg::CH_NUL, 1'b0);
    send_byte(8'h55, 1'b1);
    wait_drained();
  endtask

  // output held off while input keeps coming, then a full pause
  task test_backpressure();
    int target;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 250;
    target        = bytes_sent + 120;
    while (bytes_sent < target) send_fragment();
    wait_drained();
    target = bytes_sent + 30;
    while (bytes_sent < target) send_fragment();
    wait_drained();
  endtask

  task test_random_text(int idle_p, int stall_p, int n_items);
    int target;
    send_idle_pct = idle_p;
    stall_pct     = stall_p;
    target        = bytes_sent + n_items;
    while (bytes_sent < target) send_fragment();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_words_and_numbers();
    test_operators();
    test_comments();
    test_end_of_text();
    test_backpressure();
    test_random_text(0, 0, PHASE_ITEMS);
    test_random_text(55, 0, PHASE_ITEMS);
    test_random_text(0, 55, PHASE_ITEMS);
    test_random_text(29, 29, PHASE_ITEMS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_tokens.size() != 0)
      report_mismatch("tokens never produced, count", expected_tokens.size(), 0);

    $display("run covered %0d source bytes in %0d texts, %0d token beats checked",
             bytes_sent, texts_seen, tokens_checked);
    $display("directed lexer cases, output hold-off, random idle mixes; %0d errors",
             error_count);
    if (error_count == 0)
      $display("source_text_tokenizer_unit_tb: PASS");
    else
      $display("source_text_tokenizer_unit_tb: FAIL");
    $finish;
  end

endmodule
